### sv/lcps_pkg.sv
// Shared types and constants for the LED cube plane scanner.
package lcps_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_MARK  = 2'd2;

  // Frame store geometry.
  localparam int unsigned LATCH_COUNT = 8;
  localparam int unsigned FRAME_BYTES = 64;
  localparam int unsigned STORE_BYTES = 2 * FRAME_BYTES;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);
  localparam int unsigned LATCH_W     = $clog2(LATCH_COUNT);
  localparam int unsigned PLANE_W     = 3;
  localparam int unsigned ROW_W       = STORE_AW - LATCH_W;

  // Byte value of every frame store entry after reset.
  localparam logic [7:0] RESET_FILL = 8'h55;
  // Plane mask while the latches are being loaded.
  localparam logic [7:0] ALL_PLANES_OFF = 8'hFF;

  // Depth of the command queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One host or tick item as it arrives.
  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] byte_address;
    logic [7:0] byte_value;
  } req_t;

  // One latch load as it leaves.
  typedef struct packed {
    logic [2:0] latch_index;
    logic [7:0] column_bits;
    logic [7:0] plane_mask;
    logic       frame_swapped;
    logic       back_free;
    logic       last;
  } res_t;

  // Command handed from the front part to the back part. For a tick, the
  // upper address bits select the frame row and the latch bits are zero.
  typedef struct packed {
    logic                is_tick;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          value;
    logic [7:0]          enable;
    logic                swapped;
    logic                back_free;
  } cmd_t;

endpackage

### sv/lcps_stream_if.sv
// Valid/ready stream interface used for the request and result channels.
interface lcps_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### sv/lcps_front.sv
// Front part: accepts requests, keeps the scan control state, issues commands.
module lcps_front #(
  parameter int unsigned PLANE_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  lcps_pkg::req_t     req_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output lcps_pkg::cmd_t     cmd_o
);

  logic                         front_sel_q, front_sel_d;
  logic                         complete_q, complete_d;
  logic [lcps_pkg::PLANE_W-1:0] plane_q, plane_d;
  logic                         accept;
  logic                         last_plane;

  // A request is taken whenever the queue has room for its command.
  assign req_ready_o = cmd_ready_i;
  assign accept      = req_valid_i && cmd_ready_i;

  // The plane counter at or beyond the last plane ends a frame.
  assign last_plane = ({1'b0, plane_q} + 4'd1) >= 4'(PLANE_COUNT);

  // Classify the request and work out the next control state.
  always_comb begin
    front_sel_d   = front_sel_q;
    complete_d    = complete_q;
    plane_d       = plane_q;
    cmd_valid_o   = 1'b0;
    cmd_o         = '0;
    unique case (req_i.req_type)
      lcps_pkg::REQ_TICK: begin
        cmd_valid_o = req_valid_i;
        cmd_o.is_tick = 1'b1;
        cmd_o.addr    = {front_sel_q, plane_q, {lcps_pkg::LATCH_W{1'b0}}};
        cmd_o.enable  = lcps_pkg::ALL_PLANES_OFF ^ (8'd1 << plane_q);
        if (last_plane) begin
          plane_d = '0;
          if (complete_q) begin
            front_sel_d   = ~front_sel_q;
            complete_d    = 1'b0;
            cmd_o.swapped = 1'b1;
          end
        end else begin
          plane_d = plane_q + 3'd1;
        end
        cmd_o.back_free = ~complete_d;
      end
      lcps_pkg::REQ_WRITE: begin
        cmd_valid_o = req_valid_i;
        cmd_o.addr  = {~front_sel_q, req_i.byte_address};
        cmd_o.value = req_i.byte_value;
      end
      lcps_pkg::REQ_MARK: begin
        complete_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state registers, updated only when a request transfers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_sel_q <= 1'b0;
      complete_q  <= 1'b0;
      plane_q     <= '0;
    end else if (accept) begin
      front_sel_q <= front_sel_d;
      complete_q  <= complete_d;
      plane_q     <= plane_d;
    end
  end

  // A swap happens only at the end of a frame with a completed back frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && front_sel_d != front_sel_q) |-> (last_plane && complete_q))
    else $error("frame swap outside the end of a frame");

  // The plane counter never leaves the configured range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, plane_q} < 4'(PLANE_COUNT)))
    else $error("plane counter out of range");

  // A completed back frame stays complete until a tick swaps it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(complete_q) |-> $past(front_sel_q) != front_sel_q)
    else $error("complete flag cleared without a swap");

endmodule

### sv/lcps_queue.sv
// Short in-order command queue between the front and back parts.
module lcps_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  lcps_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output lcps_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = $clog2(lcps_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(lcps_pkg::QUEUE_DEPTH + 1);

  lcps_pkg::cmd_t entries_q [lcps_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(lcps_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_cmd_o    = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(lcps_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(lcps_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### sv/lcps_back.sv
// Back part: frame store, latch load sequencer and result register.
module lcps_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  lcps_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output lcps_pkg::res_t res_o
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_LOAD
  } state_e;

  state_e                        state_q;
  logic [lcps_pkg::ROW_W-1:0]    row_q;
  logic [lcps_pkg::LATCH_W-1:0]  latch_q;
  logic [7:0]                    enable_q;
  logic                          swapped_q;
  logic                          free_q;
  logic                          res_valid_q;
  lcps_pkg::res_t                res_q;

  logic [7:0]                    store_q [lcps_pkg::STORE_BYTES];
  logic [lcps_pkg::STORE_BYTES-1:0] written_q;
  logic [7:0]                    rd_data_q;
  logic                          rd_written_q;
  logic [lcps_pkg::STORE_AW-1:0] rd_addr;
  logic                          store_we;
  logic                          out_free;
  logic                          is_last;
  logic [7:0]                    pixel;

  assign cmd_ready_o = state_q == B_IDLE;
  assign store_we    = cmd_valid_i && cmd_ready_o && !cmd_i.is_tick;
  assign rd_addr     = {row_q, latch_q};
  assign out_free    = !res_valid_q || res_ready_i;
  assign is_last     = latch_q == lcps_pkg::LATCH_W'(lcps_pkg::LATCH_COUNT - 1);
  // An entry never written still holds its reset fill.
  assign pixel       = rd_written_q ? rd_data_q : lcps_pkg::RESET_FILL;

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Frame store: one write port for host bytes, one registered read port.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[cmd_i.addr] <= cmd_i.value;
    end
    rd_data_q    <= store_q[rd_addr];
    rd_written_q <= written_q[rd_addr];
  end

  // Sequencer: one read and one result load per latch.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      written_q   <= '0;
      res_valid_q <= 1'b0;
      latch_q     <= '0;
      row_q       <= '0;
      enable_q    <= lcps_pkg::ALL_PLANES_OFF;
      swapped_q   <= 1'b0;
      free_q      <= 1'b1;
      res_q       <= '0;
    end else begin
      // A waiting result leaves unless a new load replaces it in the same cycle.
      if (res_valid_q && res_ready_i && !(state_q == B_LOAD && out_free)) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (cmd_valid_i) begin
            if (cmd_i.is_tick) begin
              row_q     <= cmd_i.addr[lcps_pkg::STORE_AW-1:lcps_pkg::LATCH_W];
              latch_q   <= '0;
              enable_q  <= cmd_i.enable;
              swapped_q <= cmd_i.swapped;
              free_q    <= cmd_i.back_free;
              state_q   <= B_READ;
            end else begin
              written_q[cmd_i.addr] <= 1'b1;
            end
          end
        end
        B_READ: begin
          state_q <= B_LOAD;
        end
        B_LOAD: begin
          if (out_free) begin
            res_valid_q         <= 1'b1;
            res_q.latch_index   <= 3'(latch_q);
            res_q.column_bits   <= ~pixel;
            res_q.plane_mask    <= is_last ? enable_q : lcps_pkg::ALL_PLANES_OFF;
            res_q.frame_swapped <= swapped_q;
            res_q.back_free     <= free_q;
            res_q.last          <= is_last;
            if (is_last) begin
              state_q <= B_IDLE;
            end else begin
              latch_q <= latch_q + 1'b1;
              state_q <= B_READ;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  // Every read is followed by a load of the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_READ |=> state_q == B_LOAD)
    else $error("read not followed by a load");

  // Only the last load of a tick enables exactly one plane.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.last) |-> ($countones(res_q.plane_mask) == 7
                                     && res_q.latch_index == 3'd7))
    else $error("last load has a bad plane mask or latch index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.last) |-> res_q.plane_mask == lcps_pkg::ALL_PLANES_OFF)
    else $error("plane enabled before the last load");

endmodule

### sv/led_cube_plane_scanner.sv
// Top level of the LED cube plane scanner.
// The scanner takes host requests and scan ticks on req_i and returns latch loads on
// res_o. The back part stores a byte write from its idle state; a mark sends it no
// command. A scan tick gives eight latch loads; each load first reads the frame store
// through its single registered read port and then loads the result register, which
// waits while res_o stalls; the back part is free again after the last load. A two-entry
// command queue lets requests be taken while a tick is still being played out. The frame
// store comes out of reset holding 0x55 in every byte with no clearing pass: a per-byte
// written flag stands in for the fill.
module led_cube_plane_scanner #(
  parameter int unsigned PLANE_COUNT = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lcps_stream_if.sink   req_i,
  lcps_stream_if.source res_o
);

  logic           cmd_in_valid, cmd_in_ready;
  lcps_pkg::cmd_t cmd_in;
  logic           cmd_out_valid, cmd_out_ready;
  lcps_pkg::cmd_t cmd_out;
  lcps_pkg::req_t req_payload;
  lcps_pkg::res_t res_payload;

  assign req_payload   = req_i.payload;
  assign res_o.payload = res_payload;

  // Front part: request classification and scan control state.
  lcps_front #(
    .PLANE_COUNT(PLANE_COUNT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .req_i      (req_payload),
    .cmd_valid_o(cmd_in_valid),
    .cmd_ready_i(cmd_in_ready),
    .cmd_o      (cmd_in)
  );

  // Command queue.
  lcps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(cmd_in_valid),
    .push_ready_o(cmd_in_ready),
    .push_cmd_i  (cmd_in),
    .pop_valid_o (cmd_out_valid),
    .pop_ready_i (cmd_out_ready),
    .pop_cmd_o   (cmd_out)
  );

  // Back part: frame store and latch loads.
  lcps_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_out_valid),
    .cmd_ready_o(cmd_out_ready),
    .cmd_i      (cmd_out),
    .res_valid_o(res_o.valid),
    .res_ready_i(res_o.ready),
    .res_o      (res_payload)
  );

endmodule
